// ===== rtl/core/fpa_pkg.sv =====
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int QB = 33;
  localparam int RW = 65;

  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_SUB      = 4'd1;
  localparam logic [3:0] CMD_MUL      = 4'd2;
  localparam logic [3:0] CMD_DIV      = 4'd3;
  localparam logic [3:0] CMD_GT       = 4'd4;
  localparam logic [3:0] CMD_LT       = 4'd5;
  localparam logic [3:0] CMD_GE       = 4'd6;
  localparam logic [3:0] CMD_LE       = 4'd7;
  localparam logic [3:0] CMD_EQ       = 4'd8;
  localparam logic [3:0] CMD_NE       = 4'd9;
  localparam logic [3:0] CMD_MIN      = 4'd10;
  localparam logic [3:0] CMD_MAX      = 4'd11;
  localparam logic [3:0] CMD_INC      = 4'd12;
  localparam logic [3:0] CMD_DEC      = 4'd13;
  localparam logic [3:0] CMD_TO_INT   = 4'd14;
  localparam logic [3:0] CMD_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic        val_ok;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic [31:0]   res;
    logic          cmp;
    logic [1:0]    st;
    logic          neg;
    logic          div0;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [31:0]   d;
    logic [QB-1:0] q;
  } fpa_pipe_t;

  function automatic sat_t sat33(input logic [32:0] s);
    sat_t r;
    r.val_ok = (s[32] == s[31]);
    r.val    = r.val_ok ? s[31:0] : (s[32] ? NEG_LIMIT : POS_LIMIT);
    return r;
  endfunction

  function automatic sat_t from_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    if (neg) begin
      r.val_ok = (mag <= 64'(NEG_LIMIT));
      r.val    = r.val_ok ? 32'(64'd0 - mag) : NEG_LIMIT;
    end else begin
      r.val_ok = (mag <= 64'(POS_LIMIT));
      r.val    = r.val_ok ? mag[31:0] : POS_LIMIT;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fpa_if.sv =====
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] a_raw;
  logic signed [31:0] b_raw;
  modport source (output valid, cmd, a_raw, b_raw, input ready);
  modport sink   (input valid, cmd, a_raw, b_raw, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_raw;
  logic               compare_true;
  logic [1:0]         status;
  modport source (output valid, result_raw, compare_true, status, input ready);
  modport sink   (input valid, result_raw, compare_true, status, output ready);
endinterface

// ===== rtl/core/fixed_point_alu_unit.sv =====
// registered stages between input transfer and result valid are
// two front stages, one stage per quotient bit of the 33-step divider, and one output stage
// throughput: one item per cycle; the whole pipeline holds while the output is stalled
// reset: synchronous active-low rst_n clears all valid bits, payload is not reset
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_if,
  fpa_out_if.source out_if
);
  import fpa_pkg::*;

  logic        en;
  logic        out_valid;
  logic [31:0] out_res;
  logic        out_cmp;
  logic [1:0]  out_st;
  fpa_pipe_t   pipe [QB+1];

  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_if.valid),
    .in_cmd  (in_if.cmd),
    .in_a    (in_if.a_raw),
    .in_b    (in_if.b_raw),
    .pipe_o  (pipe[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_div
    fpa_div_step #(.SHIFT(QB - 1 - k)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .pipe_i(pipe[k]),
      .pipe_o(pipe[k+1])
    );
  end

  fpa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .pipe_i   (pipe[QB]),
    .out_valid(out_valid),
    .out_res  (out_res),
    .out_cmp  (out_cmp),
    .out_st   (out_st)
  );

  assign out_if.valid        = out_valid;
  assign out_if.result_raw   = out_res;
  assign out_if.compare_true = out_cmp;
  assign out_if.status       = out_st;

endmodule

// ===== rtl/core/fpa_front.sv =====
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  output fpa_pkg::fpa_pipe_t pipe_o
);
  import fpa_pkg::*;

  logic               v1_r;
  logic [3:0]         cmd1_r;
  logic [31:0]        res1_r;
  logic               cmp1_r;
  logic [1:0]         st1_r;
  logic signed [63:0] prod1_r;
  logic [RW-1:0]      n1_r;
  logic [31:0]        d1_r;
  logic               neg1_r;

  logic [31:0] res1_nxt;
  logic        cmp1_nxt;
  logic [1:0]  st1_nxt;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  sat_t        s_add, s_sub, s_inc, s_dec, s_fi;

  assign mag_a = in_a[31] ? 32'(-in_a) : in_a;
  assign mag_b = in_b[31] ? 32'(-in_b) : in_b;
  assign s_add = sat33({in_a[31], in_a} + {in_b[31], in_b});
  assign s_sub = sat33({in_a[31], in_a} - {in_b[31], in_b});
  assign s_inc = sat33({in_a[31], in_a} + 33'd1);
  assign s_dec = sat33({in_a[31], in_a} - 33'd1);
  assign s_fi  = from_mag(in_a[31], 64'(mag_a) << FRAC_BITS);

  always_comb begin
    res1_nxt = '0;
    cmp1_nxt = 1'b0;
    st1_nxt  = ST_OK;
    case (in_cmd)
      CMD_ADD: begin
        res1_nxt = s_add.val;
        st1_nxt  = s_add.val_ok ? ST_OK : ST_OVF;
      end
      CMD_SUB: begin
        res1_nxt = s_sub.val;
        st1_nxt  = s_sub.val_ok ? ST_OK : ST_OVF;
      end
      CMD_GT: cmp1_nxt = (in_a > in_b);
      CMD_LT: cmp1_nxt = (in_a < in_b);
      CMD_GE: cmp1_nxt = (in_a >= in_b);
      CMD_LE: cmp1_nxt = (in_a <= in_b);
      CMD_EQ: cmp1_nxt = (in_a == in_b);
      CMD_NE: cmp1_nxt = (in_a != in_b);
      CMD_MIN: res1_nxt = (in_a < in_b) ? in_a : in_b;
      CMD_MAX: res1_nxt = (in_a > in_b) ? in_a : in_b;
      CMD_INC: begin
        res1_nxt = s_inc.val;
        st1_nxt  = s_inc.val_ok ? ST_OK : ST_OVF;
      end
      CMD_DEC: begin
        res1_nxt = s_dec.val;
        st1_nxt  = s_dec.val_ok ? ST_OK : ST_OVF;
      end
      CMD_TO_INT: res1_nxt = in_a >>> FRAC_BITS;
      CMD_FROM_INT: begin
        res1_nxt = s_fi.val;
        st1_nxt  = s_fi.val_ok ? ST_OK : ST_OVF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_cmd;
      res1_r  <= res1_nxt;
      cmp1_r  <= cmp1_nxt;
      st1_r   <= st1_nxt;
      prod1_r <= in_a * in_b;
      n1_r    <= RW'(mag_a) << FRAC_BITS;
      d1_r    <= mag_b;
      neg1_r  <= in_a[31] ^ in_b[31];
    end
  end

  // product rounding, divider setup
  logic [63:0] pmag;
  logic [63:0] m;
  sat_t        s_mul;
  fpa_pipe_t   pipe_nxt;
  fpa_pipe_t   pipe_r;

  assign pmag  = prod1_r[63] ? 64'(-prod1_r) : 64'(prod1_r);
  assign m     = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign s_mul = from_mag(prod1_r[63], m);

  always_comb begin
    pipe_nxt        = '0;
    pipe_nxt.valid  = v1_r;
    pipe_nxt.is_div = (cmd1_r == CMD_DIV);
    pipe_nxt.res    = res1_r;
    pipe_nxt.cmp    = cmp1_r;
    pipe_nxt.st     = st1_r;
    if (cmd1_r == CMD_MUL) begin
      pipe_nxt.res = s_mul.val;
      pipe_nxt.st  = s_mul.val_ok ? ST_OK : ST_OVF;
    end
    pipe_nxt.neg  = neg1_r;
    pipe_nxt.div0 = (d1_r == 32'd0);
    pipe_nxt.ovf  = ((n1_r >> QB) >= RW'(d1_r));
    pipe_nxt.rem  = n1_r;
    pipe_nxt.d    = d1_r;
    pipe_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r.valid <= pipe_nxt.valid;
    end
    if (en) begin
      pipe_r[$bits(fpa_pipe_t)-2:0] <= pipe_nxt[$bits(fpa_pipe_t)-2:0];
    end
  end

  assign pipe_o = pipe_r;

endmodule

// ===== rtl/core/fpa_div_step.sv =====
module fpa_div_step #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fpa_pkg::fpa_pipe_t pipe_i,
  output fpa_pkg::fpa_pipe_t pipe_o
);
  import fpa_pkg::*;

  logic [RW-1:0] dsh;
  logic          take;
  fpa_pipe_t     pipe_nxt;
  fpa_pipe_t     pipe_r;

  assign dsh  = RW'(pipe_i.d) << SHIFT;
  assign take = (pipe_i.rem >= dsh);

  always_comb begin
    pipe_nxt = pipe_i;
    if (take) begin
      pipe_nxt.rem      = pipe_i.rem - dsh;
      pipe_nxt.q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r.valid <= pipe_nxt.valid;
    end
    if (en) begin
      pipe_r[$bits(fpa_pipe_t)-2:0] <= pipe_nxt[$bits(fpa_pipe_t)-2:0];
    end
  end

  assign pipe_o = pipe_r;

endmodule

// ===== rtl/core/fpa_back.sv =====
module fpa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fpa_pkg::fpa_pipe_t pipe_i,
  output logic               out_valid,
  output logic [31:0]        out_res,
  output logic               out_cmp,
  output logic [1:0]         out_st
);
  import fpa_pkg::*;

  logic        out_valid_r;
  logic [31:0] out_res_r;
  logic        out_cmp_r;
  logic [1:0]  out_st_r;

  logic [QB:0] qsum;
  logic        up;
  sat_t        s_div;
  logic [31:0] res_nxt;
  logic [1:0]  st_nxt;

  // round half up on the remainder
  assign up    = ({pipe_i.rem[QB-1:0], 1'b0} >= {2'b00, pipe_i.d});
  assign qsum  = {1'b0, pipe_i.q} + (QB+1)'(up);
  assign s_div = from_mag(pipe_i.neg, 64'(qsum));

  always_comb begin
    res_nxt = pipe_i.res;
    st_nxt  = pipe_i.st;
    if (pipe_i.is_div) begin
      if (pipe_i.div0) begin
        res_nxt = '0;
        st_nxt  = ST_DZ;
      end else if (pipe_i.ovf) begin
        res_nxt = pipe_i.neg ? NEG_LIMIT : POS_LIMIT;
        st_nxt  = ST_OVF;
      end else begin
        res_nxt = s_div.val;
        st_nxt  = s_div.val_ok ? ST_OK : ST_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
      out_cmp_r <= pipe_i.cmp;
      out_st_r  <= st_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_cmp   = out_cmp_r;
  assign out_st    = out_st_r;

endmodule

// ===== rtl/core/fpa_checker.sv =====
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic        out_cmp,
  input logic [1:0]  out_status
);
  import fpa_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmp |-> out_result == 32'd0 && out_status == ST_OK)
    else $error("comparison carries a value or status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_DZ || out_status == ST_OVF)
    else $error("bad status code");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DZ |-> out_result == 32'd0 && !out_cmp)
    else $error("divide by zero result not zero");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_result(out_if.result_raw),
  .out_cmp   (out_if.compare_true),
  .out_status(out_if.status)
);

// ===== bench/fixed_point_alu_unit_tb.sv =====
module fixed_point_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1130;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;
  } alu_result_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    alu_result_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fails = 0;
  int   idle_cycles = 0;
  alu_result_t pending_results[$];
  alu_result_t table_results[$];
  bit          table_flags[$];

  fpa_in_if  in_if ();
  fpa_out_if out_if ();

  fixed_point_alu_unit #(.FRAC_BITS(FB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #1 clk = ~clk;

  function automatic alu_result_t saturate_mag(bit neg, logic [63:0] mag);
    alu_result_t r;
    r = '0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.res = NEG_LIMIT;
        r.st  = ST_OVF;
      end else begin
        r.res = 32'(64'd0 - mag);
      end
    end else if (mag > 64'h7fff_ffff) begin
      r.res = POS_LIMIT;
      r.st  = ST_OVF;
    end else begin
      r.res = mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] cmd, logic [31:0] a_bits,
                                              logic [31:0] b_bits);
    longint      a;
    longint      b;
    longint      p;
    logic [63:0] n;
    logic [63:0] d;
    alu_result_t r;
    a = longint'($signed(a_bits));
    b = longint'($signed(b_bits));
    r = '0;
    case (cmd)
      CMD_ADD:      r = saturate_mag(a + b < 0, magnitude(a + b));
      CMD_SUB:      r = saturate_mag(a - b < 0, magnitude(a - b));
      CMD_MUL: begin
        p = a * b;
        r = saturate_mag(p < 0, (magnitude(p) + (64'd1 << (FB - 1))) >> FB);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.st = ST_DZ;
        end else begin
          n = magnitude(a) << FB;
          d = magnitude(b);
          r = saturate_mag((a < 0) != (b < 0), (2 * n + d) / (2 * d));
        end
      end
      CMD_GT:       r.cmp = a > b;
      CMD_LT:       r.cmp = a < b;
      CMD_GE:       r.cmp = a >= b;
      CMD_LE:       r.cmp = a <= b;
      CMD_EQ:       r.cmp = a == b;
      CMD_NE:       r.cmp = a != b;
      CMD_MIN:      r.res = (a < b) ? a_bits : b_bits;
      CMD_MAX:      r.res = (a > b) ? a_bits : b_bits;
      CMD_INC:      r = saturate_mag(a + 1 < 0, magnitude(a + 1));
      CMD_DEC:      r = saturate_mag(a - 1 < 0, magnitude(a - 1));
      CMD_TO_INT:   r.res = 32'(a >>> FB);
      CMD_FROM_INT: r = saturate_mag(a < 0, magnitude(a) << FB);
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return POS_LIMIT - $urandom_range(0, 3);
      1:       return NEG_LIMIT + $urandom_range(0, 3);
      2:       return 32'($signed($urandom_range(0, 1024)) - 512);
      3:       return '0;
      4, 5:    return 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      default: return $urandom;
    endcase
  endfunction

  // transfers on both channels, checking and watchdog
  always @(posedge clk) begin
    alu_result_t want;
    alu_result_t got;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_if.valid && in_if.ready)
        pending_results.push_back(compute_alu(in_if.cmd, in_if.a_raw, in_if.b_raw));
      if (out_if.valid && out_if.ready) begin
        got = {out_if.result_raw, out_if.compare_true, out_if.status};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result res=%h cmp=%b st=%0d", $time,
                   got.res, got.cmp, got.st);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (table_flags.size() != 0) begin
            if (table_flags.pop_front()) begin
              want = table_results.pop_front();
            end
          end
          if (got.res !== want.res) begin
            $display("%0t: result_raw expected %h actual %h", $time, want.res, got.res);
            fails++;
          end
          if (got.cmp !== want.cmp) begin
            $display("%0t: compare_true expected %b actual %b", $time, want.cmp, got.cmp);
            fails++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            fails++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fixed_point_alu_unit verification failed");
        $finish;
      end
    end
  end

  // receiver stalls in phases: free flow, random, or random with ready mostly low
  always @(posedge clk) begin
    int mode;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      mode = int'(($time / 400) % 3);
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 9) > 6);
      endcase
    end
  end

  task automatic send_item(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.a_raw <= a;
    in_if.b_raw <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic pause_sender(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  vector_t vectors[] = '{
    '{CMD_ADD, POS_LIMIT, 32'd1, 1, '{POS_LIMIT, 1'b0, ST_OVF}},
    '{CMD_ADD, NEG_LIMIT, NEG_LIMIT, 1, '{NEG_LIMIT, 1'b0, ST_OVF}},
    '{CMD_SUB, NEG_LIMIT, 32'd1, 1, '{NEG_LIMIT, 1'b0, ST_OVF}},
    '{CMD_SUB, 32'd0, NEG_LIMIT, 1, '{POS_LIMIT, 1'b0, ST_OVF}},
    '{CMD_MUL, 32'h100, 32'h100, 1, '{32'h100, 1'b0, ST_OK}},
    '{CMD_MUL, POS_LIMIT, POS_LIMIT, 1, '{POS_LIMIT, 1'b0, ST_OVF}},
    '{CMD_MUL, NEG_LIMIT, POS_LIMIT, 1, '{NEG_LIMIT, 1'b0, ST_OVF}},
    '{CMD_MUL, 32'hffff_ff80, 32'd1, 0, '0},
    '{CMD_DIV, 32'h1234, 32'd0, 1, '{32'd0, 1'b0, ST_DZ}},
    '{CMD_DIV, NEG_LIMIT, 32'hffff_ffff, 1, '{POS_LIMIT, 1'b0, ST_OVF}},
    '{CMD_DIV, 32'h100, 32'h300, 0, '0},
    '{CMD_DIV, 32'hffff_ff00, 32'h200, 0, '0},
    '{CMD_GT, POS_LIMIT, NEG_LIMIT, 1, '{32'd0, 1'b1, ST_OK}},
    '{CMD_LT, POS_LIMIT, NEG_LIMIT, 1, '{32'd0, 1'b0, ST_OK}},
    '{CMD_GE, 32'd5, 32'd5, 1, '{32'd0, 1'b1, ST_OK}},
    '{CMD_LE, NEG_LIMIT, NEG_LIMIT, 1, '{32'd0, 1'b1, ST_OK}},
    '{CMD_EQ, 32'hffff_ffff, 32'hffff_ffff, 1, '{32'd0, 1'b1, ST_OK}},
    '{CMD_NE, 32'd0, 32'd0, 1, '{32'd0, 1'b0, ST_OK}},
    '{CMD_MIN, NEG_LIMIT, POS_LIMIT, 1, '{NEG_LIMIT, 1'b0, ST_OK}},
    '{CMD_MAX, NEG_LIMIT, POS_LIMIT, 1, '{POS_LIMIT, 1'b0, ST_OK}},
    '{CMD_INC, POS_LIMIT, 32'hffff_ffff, 1, '{POS_LIMIT, 1'b0, ST_OVF}},
    '{CMD_DEC, NEG_LIMIT, 32'hffff_ffff, 1, '{NEG_LIMIT, 1'b0, ST_OVF}},
    '{CMD_TO_INT, 32'hffff_ff01, 32'd0, 0, '0},
    '{CMD_TO_INT, POS_LIMIT, 32'd0, 0, '0},
    '{CMD_FROM_INT, 32'h0100_0000, 32'd0, 1, '{POS_LIMIT, 1'b0, ST_OVF}}
  };

  initial begin
    int burst;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd   <= CMD_ADD;
    in_if.a_raw <= '0;
    in_if.b_raw <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      table_flags.push_back(vectors[i].typed);
      if (vectors[i].typed)
        table_results.push_back(vectors[i].want);
      send_item(vectors[i].cmd, vectors[i].a, vectors[i].b);
      if ($urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 4));
    end

    burst = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        if (i > 300 && i < 500)
          burst = 40;
        else begin
          pause_sender($urandom_range(1, 6));
          burst = $urandom_range(1, 20);
        end
      end
      burst--;
      send_item(4'($urandom_range(0, 15)), pick_operand(),
                ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand());
    end
    in_if.valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("fixed_point_alu_unit verification clean");
    else
      $display("fixed_point_alu_unit verification failed");
    $finish;
  end
endmodule
